### design/lqe_pkg.sv
package lqe_pkg;

  // Operation codes carried in the op field
  localparam logic [2:0] OP_RTT   = 3'd0;
  localparam logic [2:0] OP_BW    = 3'd1;
  localparam logic [2:0] OP_SCORE = 3'd2;
  localparam logic [2:0] OP_TICK  = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  localparam int unsigned DEF_HOST_ENTRIES = 64;

  localparam int unsigned SAMPLE_W = 20;
  localparam int unsigned SCORE_W  = 28;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned ALPHA_W  = 9;
  localparam int unsigned EXPIRY_W = 16;
  localparam int unsigned NUM_W    = 16;

  localparam logic [ALPHA_W-1:0]  ALPHA_ONE     = 9'd256;
  localparam logic [ALPHA_W-1:0]  ALPHA_RESET   = 9'd51;
  localparam logic [EXPIRY_W-1:0] EXPIRY_RESET  = 16'd300;
  localparam logic [SAMPLE_W-1:0] RTT_FLOOR     = 20'd16;
  localparam logic [NUM_W-1:0]    RTT_NUMERATOR = 16'd40960;
  localparam logic [SCORE_W-1:0]  SCORE_MAX     = 28'hFFFFFFF;

  // Register byte addresses (bit 2 selects the register)
  localparam logic REG_ALPHA  = 1'b0;
  localparam logic REG_EXPIRY = 1'b1;

  typedef struct packed {
    logic [2:0]          op;
    logic [5:0]          host_index;
    logic [SAMPLE_W-1:0] sample_value;
  } req_word_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score_value;
    logic               entry_known;
  } rsp_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_CHECK,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic tick;
    logic clear;
    logic write;
    logic check;
    logic div_step;
    logic result;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic req_sample;
    logic req_score;
    logic req_tick;
    logic req_clear;
    logic div_last;
    logic rsp_free;
  } status_t;

endpackage

### design/lqe_ctrl.sv
module lqe_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  lqe_pkg::status_t st,
  output lqe_pkg::cmd_t    cmd
);
  import lqe_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          cmd.tick    = st.req_tick;
          cmd.clear   = st.req_clear;
          if (st.req_sample) begin
            state_next = ST_UPDATE;
          end else if (st.req_score) begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_UPDATE: begin
        cmd.write  = 1'b1;
        state_next = ST_IDLE;
      end
      ST_CHECK: begin
        cmd.check  = 1'b1;
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (st.rsp_free) begin
          cmd.result = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### design/lqe_dp.sv
module lqe_dp #(
  parameter int unsigned HOST_ENTRIES = lqe_pkg::DEF_HOST_ENTRIES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  lqe_pkg::req_word_t               req_word,
  output lqe_pkg::rsp_word_t               rsp_word,
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  input  logic [lqe_pkg::ALPHA_W-1:0]      alpha,
  input  logic [lqe_pkg::EXPIRY_W-1:0]     expiry,
  input  lqe_pkg::cmd_t                    cmd,
  output lqe_pkg::status_t                 st
);
  import lqe_pkg::*;

  localparam int unsigned AW    = (HOST_ENTRIES > 1) ? $clog2(HOST_ENTRIES) : 1;
  localparam int unsigned WORD_W = 2 * SAMPLE_W + STAMP_W;

  // Entry word: rtt average, bandwidth average, stamp
  logic [WORD_W-1:0] mem [HOST_ENTRIES];
  logic [WORD_W-1:0] rd_data;
  logic [WORD_W-1:0] wr_data;

  logic [HOST_ENTRIES-1:0] rtt_known;
  logic [HOST_ENTRIES-1:0] bw_known;
  logic [STAMP_W-1:0]      seconds_now;

  logic [2:0]          op_q;
  logic [AW-1:0]       addr_q;
  logic                host_ok_q;
  logic [SAMPLE_W-1:0] sample_q;

  logic [AW+5:0] host_ext;
  logic [AW-1:0] req_addr;
  logic          req_host_ok;

  // Decode the incoming word
  assign host_ext    = {{AW{1'b0}}, req_word.host_index};
  assign req_addr    = host_ext[AW-1:0];
  assign req_host_ok = host_ext < (AW+6)'(HOST_ENTRIES);

  assign st.req_sample = ((req_word.op == OP_RTT) || (req_word.op == OP_BW)) &&
                         (req_word.sample_value != '0) && req_host_ok;
  assign st.req_score  = (req_word.op == OP_SCORE);
  assign st.req_tick   = (req_word.op == OP_TICK);
  assign st.req_clear  = (req_word.op == OP_CLEAR);

  // Hold the accepted word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q      <= req_word.op;
      addr_q    <= req_addr;
      host_ok_q <= req_host_ok;
      sample_q  <= req_word.sample_value;
    end
  end

  // Entry memory, read on accept
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_data <= mem[req_addr];
    end
    if (cmd.write) begin
      mem[addr_q] <= wr_data;
    end
  end

  logic [SAMPLE_W-1:0] old_rtt, old_bw, old_avg, new_avg;
  logic [STAMP_W-1:0]  old_stamp;
  logic                is_rtt, old_known;
  logic [ALPHA_W-1:0]  alpha_c;
  logic signed [SAMPLE_W:0]  diff;
  logic signed [ALPHA_W:0]   alpha_s;
  logic signed [31:0]        mix;

  assign old_rtt   = rd_data[WORD_W-1 -: SAMPLE_W];
  assign old_bw    = rd_data[STAMP_W +: SAMPLE_W];
  assign old_stamp = rd_data[STAMP_W-1:0];
  assign is_rtt    = (op_q == OP_RTT);
  assign old_avg   = is_rtt ? old_rtt : old_bw;
  assign old_known = is_rtt ? rtt_known[addr_q] : bw_known[addr_q];

  // Blend: old + a*(sample - old)/256, rounded half up
  assign alpha_c = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
  assign alpha_s = $signed({1'b0, alpha_c});
  assign diff    = $signed({1'b0, sample_q}) - $signed({1'b0, old_avg});
  assign mix     = $signed({4'b0, old_avg, 8'b0}) + alpha_s * diff + 32'sd128;
  assign new_avg = old_known ? mix[SAMPLE_W+7:8] : sample_q;
  assign wr_data = is_rtt ? {new_avg, old_bw, seconds_now}
                          : {old_rtt, new_avg, seconds_now};

  // Known bits and seconds count
  always_ff @(posedge clk) begin
    if (rst) begin
      rtt_known   <= '0;
      bw_known    <= '0;
      seconds_now <= '0;
    end else begin
      if (cmd.tick) begin
        seconds_now <= seconds_now + 1'b1;
      end
      if (cmd.clear) begin
        rtt_known <= '0;
        bw_known  <= '0;
      end else if (cmd.write) begin
        if (is_rtt) begin
          rtt_known[addr_q] <= 1'b1;
        end else begin
          bw_known[addr_q] <= 1'b1;
        end
      end
    end
  end

  // Freshness check
  logic                fresh, stale, rk, bk;
  logic [STAMP_W-1:0]  age;
  assign rk    = host_ok_q && rtt_known[addr_q];
  assign bk    = host_ok_q && bw_known[addr_q];
  assign age   = seconds_now - old_stamp;
  assign stale = (old_stamp != '0) && (age > {16'b0, expiry});
  assign fresh = (rk || bk) && !stale;

  // Restoring divider for 40960 / max(rtt, 16)
  logic                fresh_q, rk_q, bk_q;
  logic [SAMPLE_W-1:0] divisor, bw_q;
  logic [SAMPLE_W:0]   rem, rem_sh;
  logic [NUM_W-1:0]    quot;
  logic [3:0]          cnt;
  logic [3:0]          bit_idx;

  assign bit_idx     = 4'(NUM_W - 1) - cnt;
  assign rem_sh      = {rem[SAMPLE_W-1:0], RTT_NUMERATOR[bit_idx]};
  assign st.div_last = (cnt == 4'(NUM_W - 1));

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      fresh_q <= fresh;
      rk_q    <= rk;
      bk_q    <= bk;
      bw_q    <= old_bw;
      divisor <= (old_rtt < RTT_FLOOR) ? RTT_FLOOR : old_rtt;
      rem     <= '0;
      quot    <= '0;
      cnt     <= '0;
    end else if (cmd.div_step) begin
      cnt <= cnt + 1'b1;
      if (rem_sh >= {1'b0, divisor}) begin
        rem  <= rem_sh - {1'b0, divisor};
        quot <= {quot[NUM_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        quot <= {quot[NUM_W-2:0], 1'b0};
      end
    end
  end

  // Score sum with saturation
  logic [SCORE_W:0] sum;
  assign sum = (rk_q ? (SCORE_W+1)'(quot) : '0) +
               (bk_q ? (SCORE_W+1)'({bw_q, 4'b0}) : '0);

  // Output register
  assign st.rsp_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.result) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result) begin
      rsp_word.entry_known <= fresh_q;
      if (!fresh_q) begin
        rsp_word.score_value <= '0;
      end else if (sum > {1'b0, SCORE_MAX}) begin
        rsp_word.score_value <= SCORE_MAX;
      end else begin
        rsp_word.score_value <= sum[SCORE_W-1:0];
      end
    end
  end

endmodule

### design/link_quality_ema_scorer.sv
// Link quality table with per-host moving averages of rtt and bandwidth.
// Request channel (req_valid/req_ready/req_word) takes one word per item:
// rtt sample, bandwidth sample, score query, one-second tick or clear.
// Only a score query produces a word on the response channel
// (rsp_valid/rsp_ready/rsp_word).
// A tick or clear is done on accept, a sample takes a read, then a
// write of the entry memory, and a score query reaches the response
// register through one read, one freshness check, 16 steps of the
// restoring divider for the rtt term, and the load of the result.
// A new request is taken while an earlier response still waits; a query
// that finishes while the response register is full holds until the
// receiver takes it.
// Reset clears the known bits, the seconds count and response valid, and
// loads the register defaults (weight 51, expiry 300 s). Registers sit on
// the APB port: weight at 0x0, expiry at 0x4.
module link_quality_ema_scorer #(
  parameter int unsigned HOST_ENTRIES = lqe_pkg::DEF_HOST_ENTRIES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  lqe_pkg::req_word_t req_word,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output lqe_pkg::rsp_word_t rsp_word,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import lqe_pkg::*;

  logic [ALPHA_W-1:0]  alpha;
  logic [EXPIRY_W-1:0] expiry;
  cmd_t                cmd;
  status_t             st;

  // Configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha  <= ALPHA_RESET;
      expiry <= EXPIRY_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_ALPHA:  alpha  <= pwdata[ALPHA_W-1:0];
        REG_EXPIRY: expiry <= pwdata[EXPIRY_W-1:0];
        default:    alpha  <= alpha;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_EXPIRY) ? {16'b0, expiry} : {23'b0, alpha};

  lqe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .st        (st),
    .cmd       (cmd)
  );

  lqe_dp #(
    .HOST_ENTRIES (HOST_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_word  (req_word),
    .rsp_word  (rsp_word),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .alpha     (alpha),
    .expiry    (expiry),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

### design/lqe_checker.sv
module lqe_checker (
  input logic               clk,
  input logic               rst,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input lqe_pkg::rsp_word_t rsp_word,
  input logic               pready
);

  // A stalled response word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
    else $error("response word changed while stalled");

  // No response right after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  // An unknown host scores zero
  a_unknown_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_word.entry_known |-> rsp_word.score_value == '0)
    else $error("nonzero score for unknown entry");

  // Register port never waits
  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind link_quality_ema_scorer lqe_checker u_lqe_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp_word  (rsp_word),
  .pready    (pready)
);

### verif/tb_link_quality_ema_scorer.sv
`timescale 1ns / 100ps

module tb_link_quality_ema_scorer;
  import lqe_pkg::*;

  // Scoreboard: keeps its own copy of the host table and the score words it expects
  class quality_board;
    bit [8:0]  weight;
    bit [15:0] expiry;
    bit        rtt_seen[64];
    bit        bw_seen[64];
    bit [19:0] rtt_avg[64];
    bit [19:0] bw_avg[64];
    bit [31:0] stamp[64];
    bit [31:0] seconds;
    rsp_word_t score_queue[$];
    int        errors;

    function void clear_table();
      weight  = 9'd51;
      expiry  = 16'd300;
      seconds = 0;
      errors  = 0;
      for (int i = 0; i < 64; i++) begin
        rtt_seen[i] = 0;
        bw_seen[i]  = 0;
        rtt_avg[i]  = 0;
        bw_avg[i]   = 0;
        stamp[i]    = 0;
      end
    endfunction

    // Blend a new sample into the average, weight capped at one, round half up
    function bit [19:0] blend(bit [19:0] old, bit [19:0] smp);
      longint unsigned a, mix;
      a = (weight > 9'd256) ? 256 : weight;
      mix = a * smp + (256 - a) * old + 128;
      return mix[27:8];
    endfunction

    // Note an accepted request word and queue the score it will produce
    function void note_request(req_word_t w);
      rsp_word_t       r;
      longint unsigned s;
      bit [19:0]       rt;
      int              h;
      h = w.host_index;
      case (w.op)
        OP_RTT: if (w.sample_value != 0) begin
          rtt_avg[h]  = rtt_seen[h] ? blend(rtt_avg[h], w.sample_value) : w.sample_value;
          rtt_seen[h] = 1;
          stamp[h]    = seconds;
        end
        OP_BW: if (w.sample_value != 0) begin
          bw_avg[h]  = bw_seen[h] ? blend(bw_avg[h], w.sample_value) : w.sample_value;
          bw_seen[h] = 1;
          stamp[h]   = seconds;
        end
        OP_TICK: seconds = seconds + 1;
        OP_CLEAR: for (int i = 0; i < 64; i++) begin
          rtt_seen[i] = 0;
          bw_seen[i]  = 0;
        end
        OP_SCORE: begin
          r = '0;
          if ((rtt_seen[h] || bw_seen[h]) &&
              !(stamp[h] != 0 && (seconds - stamp[h]) > {16'd0, expiry})) begin
            s = 0;
            if (rtt_seen[h]) begin
              rt = (rtt_avg[h] < 20'd16) ? 20'd16 : rtt_avg[h];
              s += 40960 / rt;
            end
            if (bw_seen[h]) s += longint'(bw_avg[h]) << 4;
            if (s > 64'h0FFFFFFF) s = 64'h0FFFFFFF;
            r.score_value = s[27:0];
            r.entry_known = 1'b1;
          end
          score_queue.push_back(r);
        end
        default: ;
      endcase
    endfunction

    // Compare a delivered score word with the oldest one expected
    function void check_score(rsp_word_t got);
      rsp_word_t want;
      if (score_queue.size() == 0) begin
        $error("unexpected score word %h", got);
        errors++;
        return;
      end
      want = score_queue.pop_front();
      if (got.score_value !== want.score_value) begin
        $error("score_value expected %h actual %h", want.score_value, got.score_value);
        errors++;
      end
      if (got.entry_known !== want.entry_known) begin
        $error("entry_known expected %b actual %b", want.entry_known, got.entry_known);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  req_word_t   req_word;
  logic        rsp_valid;
  logic        rsp_ready;
  rsp_word_t   rsp_word;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  quality_board board;
  bit           hold_rsp;

  link_quality_ema_scorer dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Hold the request word until the block takes it, then note it
  task automatic send_word(req_word_t w);
    req_valid <= 1'b1;
    req_word  <= w;
    do @(posedge clk); while (!req_ready);
    board.note_request(w);
  endtask

  task automatic send_op(logic [2:0] op, int host, logic [19:0] smp);
    req_word_t w;
    w.op           = op;
    w.host_index   = host[5:0];
    w.sample_value = smp;
    send_word(w);
  endtask

  // Setup and access cycle of one register write
  task automatic write_reg(logic sel, logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (sel == REG_ALPHA) board.weight = value[8:0];
    else board.expiry = value[15:0];
  endtask

  // Drain every pending score, then let a sample in flight settle
  task automatic wait_quiet();
    req_valid <= 1'b0;
    while (board.score_queue.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic req_word_t random_word();
    req_word_t w;
    int        pick;
    pick = $urandom_range(99);
    if (pick < 27) w.op = OP_RTT;
    else if (pick < 54) w.op = OP_BW;
    else if (pick < 84) w.op = OP_SCORE;
    else if (pick < 94) w.op = OP_TICK;
    else if (pick < 96) w.op = OP_CLEAR;
    else w.op = 3'($urandom_range(5, 7));
    w.host_index = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(7));
    pick = $urandom_range(9);
    if (pick == 0) w.sample_value = '0;
    else if (pick == 1) w.sample_value = '1;
    else if (pick < 6) w.sample_value = 20'($urandom_range(1, 400));
    else w.sample_value = 20'($urandom);
    return w;
  endfunction

  // Send bursts of random length with random gaps
  task automatic random_traffic(int count);
    int left, burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst && left > 0; i++, left--) send_word(random_word());
      if ($urandom_range(3) != 0) begin
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
    req_valid <= 1'b0;
  endtask

  // Stall the response side on its own pattern, with one long hold-off on request
  initial begin
    int mode, stretch;
    rsp_ready <= 1'b0;
    mode    = 0;
    stretch = 0;
    forever begin
      @(posedge clk);
      if (hold_rsp) begin
        rsp_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_rsp = 0;
      end else begin
        if (stretch == 0) begin
          mode    = $urandom_range(2);
          stretch = $urandom_range(10, 80);
        end
        stretch--;
        case (mode)
          0: rsp_ready <= 1'b1;
          1: rsp_ready <= 1'($urandom);
          default: rsp_ready <= ($urandom_range(7) == 0);
        endcase
      end
    end
  end

  // Check every score word the block hands over
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) board.check_score(rsp_word);
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    board = new();
    board.clear_table();
    hold_rsp = 0;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req_word  <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: unknown entry, seeding at second zero, floor, zero samples, ops
    send_op(OP_SCORE, 0, 20'd0);
    send_op(OP_RTT, 0, 20'd0);
    send_op(OP_SCORE, 0, 20'd5);
    send_op(OP_RTT, 0, 20'd1);
    send_op(OP_SCORE, 0, 20'd0);
    send_op(OP_RTT, 0, 20'hFFFFF);
    send_op(OP_SCORE, 0, 20'd0);
    send_op(OP_BW, 63, 20'hFFFFF);
    send_op(OP_RTT, 63, 20'd16);
    send_op(OP_SCORE, 63, 20'hFFFFF);
    send_op(OP_BW, 63, 20'd0);
    send_op(OP_BW, 63, 20'd1);
    send_op(OP_SCORE, 63, 20'd0);
    send_op(OP_BW, 42, 20'h5A5A5);
    send_op(3'd5, 42, 20'hFFFFF);
    send_op(3'd7, 21, 20'hAAAAA);
    send_op(OP_TICK, 0, 20'd0);
    send_op(OP_RTT, 21, 20'd17);
    send_op(OP_SCORE, 21, 20'd0);
    send_op(OP_SCORE, 42, 20'd0);
    send_op(OP_CLEAR, 0, 20'd0);
    send_op(OP_SCORE, 63, 20'd0);
    send_op(3'd6, 1, 20'h55555);
    wait_quiet();

    // Walk through settings, extremes included
    write_reg(REG_ALPHA, 32'd0);
    write_reg(REG_EXPIRY, 32'd0);
    random_traffic(110);
    wait_quiet();
    write_reg(REG_ALPHA, 32'd256);
    write_reg(REG_EXPIRY, 32'd65535);
    random_traffic(110);
    wait_quiet();
    write_reg(REG_ALPHA, 32'd511);
    write_reg(REG_EXPIRY, 32'd3);
    random_traffic(110);
    wait_quiet();

    // Block the response side while queries keep coming
    write_reg(REG_ALPHA, 32'd128);
    write_reg(REG_EXPIRY, 32'd1);
    hold_rsp = 1;
    for (int i = 0; i < 20; i++) send_op(OP_SCORE, $urandom_range(7), 20'($urandom));
    random_traffic(110);
    wait_quiet();
    write_reg(REG_ALPHA, 32'($urandom_range(511)));
    write_reg(REG_EXPIRY, 32'($urandom_range(2, 20)));
    random_traffic(110);
    wait_quiet();
    write_reg(REG_ALPHA, 32'd51);
    write_reg(REG_EXPIRY, 32'd300);
    random_traffic(110);
    wait_quiet();

    if (board.errors == 0 && board.score_queue.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

### files.f
design/lqe_pkg.sv
design/lqe_ctrl.sv
design/lqe_dp.sv
design/link_quality_ema_scorer.sv
design/lqe_checker.sv
verif/tb_link_quality_ema_scorer.sv
